### rtl/fsa_pkg.sv
// Shared types, constants and codes of the fit strategy segment allocator.
`default_nettype none
package fsa_pkg;

  // Pool and table geometry.
  localparam int POOL_BYTES   = 65536;
  localparam int MAX_SEGMENTS = 64;
  localparam int AW = 16;  // segment start width
  localparam int SW = 17;  // segment size width
  localparam int CW = 7;   // segment count width
  localparam int IW = 6;   // table index width

  // One table entry.
  typedef struct packed {
    logic [AW-1:0] start;
    logic [SW-1:0] size;
    logic          used;
  } seg_t;

  // Request opcodes.
  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_QUERY  = 2'd2,
    OP_REINIT = 2'd3
  } op_t;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_NOTFND  = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // Fit strategies.
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;
  localparam logic [1:0] FIT_NEXT  = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_FIT  = 1'b0;
  localparam logic CFG_POOL = 1'b1;

  // Per-entry compare results from the shared scan unit.
  typedef struct packed {
    logic fits;
    logic smaller;
    logic larger;
    logic free_match;
    logic probe_hit;
    logic small_hit;
  } scan_flags_t;

endpackage
`default_nettype wire

### rtl/fsa_scan_unit.sv
// Shared compare unit that classifies one table entry per cycle.
`default_nettype none
module fsa_scan_unit (
  input  fsa_pkg::seg_t          entry,
  input  logic [fsa_pkg::SW-1:0] req_size,
  input  logic [fsa_pkg::SW-1:0] best_size,
  input  logic [fsa_pkg::SW-1:0] small_limit,
  input  logic [fsa_pkg::AW-1:0] target_addr,
  output fsa_pkg::scan_flags_t   flags
);

  logic [fsa_pkg::SW:0] seg_end;

  // End of the entry, one bit wider so a segment reaching the pool top is exact.
  assign seg_end = {1'b0, entry.size} + {2'b00, entry.start};

  always_comb begin
    flags.fits       = !entry.used && (entry.size >= req_size);
    flags.smaller    = entry.size < best_size;
    flags.larger     = entry.size > best_size;
    flags.free_match = entry.used && (entry.start == target_addr);
    flags.probe_hit  = entry.used && (target_addr >= entry.start) &&
                       ({2'b00, target_addr} < seg_end);
    flags.small_hit  = !entry.used && (entry.size <= small_limit);
  end

endmodule
`default_nettype wire

### rtl/fit_strategy_segment_allocator_core.sv
// Top level: sequencer, segment table memory and statistics of the allocator.
//
// Usage: requests enter on the in_ stream (opcode in in_tuser, the other
// fields in in_tdata); each request returns exactly one result item on the
// out_ stream. cfg_wr_en writes fit_strategy (index 0) or pool_bytes
// (index 1); pool_bytes takes effect at the next reinitialize.
// Timing: the sequencer walks the table one entry per cycle through a
// single read port. A query or reinitialize makes one statistics pass over
// the table; a free or allocate first makes a search pass and moves the
// table entries that a split or merge needs before its statistics pass.
// in_tready is high only while the sequencer is idle; one item is worked on
// at a time.
// Reset: the table holds one free segment spanning 65536 bytes; the
// S_INIT state writes that entry after reset, then in_tready rises.
// Stall: a finished result waits in the output register; the next item may
// be accepted and worked on meanwhile, and its result waits until the
// output register is taken.
`default_nettype none
module fit_strategy_segment_allocator_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input item: tuser = opcode[1:0].
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [1:0]  in_tuser,
  // tdata = req_size[16:0], target_addr[32:17], small_limit[49:33], zero fill.
  input  wire logic [55:0] in_tdata,
  // Result item: tdata = status[1:0], block_offset[17:2], hole_count[24:18],
  // allocated_bytes[41:25], free_bytes[58:42], largest_hole[75:59],
  // small_hole_count[82:76], probe_allocated[83], zero fill.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata,
  // Configuration write port.
  input  wire logic        cfg_wr_en,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [16:0] cfg_wdata
);

  localparam int AW = fsa_pkg::AW;
  localparam int SW = fsa_pkg::SW;
  localparam int CW = fsa_pkg::CW;
  localparam int IW = fsa_pkg::IW;

  typedef enum logic [9:0] {
    S_INIT  = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_SRCH  = 10'b0000000100,
    S_SHUP  = 10'b0000001000,
    S_WSPL  = 10'b0000010000,
    S_WIDX  = 10'b0000100000,
    S_FWR   = 10'b0001000000,
    S_SHDN  = 10'b0010000000,
    S_STAT  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  // Segment table memory.
  fsa_pkg::seg_t mem [fsa_pkg::MAX_SEGMENTS];
  fsa_pkg::seg_t rd_q;
  logic [IW-1:0] rd_addr;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  fsa_pkg::seg_t mem_wd;

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] rover_r, rover_nxt;
  logic [SW-1:0] inuse_r, inuse_nxt;
  logic [SW-1:0] pool_r, pool_nxt;
  logic [1:0]    fit_r;
  logic [SW-1:0] cfgpool_r;

  // Request registers.
  fsa_pkg::op_t  op_r, op_nxt;
  logic [SW-1:0] req_r, req_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [SW-1:0] lim_r, lim_nxt;

  // Scan control.
  logic [CW-1:0] n_r, n_nxt;
  logic [IW-1:0] r0_r, r0_nxt;
  logic          qv_r, qv_nxt;
  logic [IW-1:0] qi_r, qi_nxt;

  // Search results.
  logic          found_r, found_nxt;
  logic [IW-1:0] bidx_r, bidx_nxt;
  logic [AW-1:0] bstart_r, bstart_nxt;
  logic [SW-1:0] bsize_r, bsize_nxt;
  logic          left_r, left_nxt;
  logic          right_r, right_nxt;
  logic [AW-1:0] lstart_r, lstart_nxt;
  logic [SW-1:0] lsize_r, lsize_nxt;
  logic [SW-1:0] rsize_r, rsize_nxt;
  fsa_pkg::seg_t pv_r, pv_nxt;

  // Table move control.
  logic [CW-1:0] p_r, p_nxt;
  logic          pend_r, pend_nxt;
  logic [IW-1:0] pwa_r, pwa_nxt;
  logic [1:0]    k_r, k_nxt;

  // Result accumulation.
  logic [1:0]    status_r, status_nxt;
  logic [AW-1:0] off_r, off_nxt;
  logic [CW-1:0] holes_r, holes_nxt;
  logic [CW-1:0] small_r, small_nxt;
  logic [SW-1:0] largest_r, largest_nxt;
  logic          probe_r, probe_nxt;

  // Output register.
  logic          ovalid_r, ovalid_nxt;
  logic [87:0]   odata_r, odata_nxt;

  fsa_pkg::scan_flags_t flags;

  // Locals of the sequencer.
  logic          start_stat;
  logic [CW-1:0] scan_sum;
  logic [IW-1:0] merge_idx;
  logic [1:0]    merge_k;
  logic [CW-1:0] rov_ext;
  logic [CW-1:0] mk_end;
  logic [SW:0]   need;
  logic [SW-1:0] init_pool;
  logic [SW-1:0] merged_size;

  fsa_scan_unit u_scan (
    .entry       (rd_q),
    .req_size    (req_r),
    .best_size   (bsize_r),
    .small_limit (lim_r),
    .target_addr (addr_r),
    .flags       (flags)
  );

  // Memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[rd_addr];
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_r     <= fsa_pkg::FIT_FIRST;
      cfgpool_r <= SW'(fsa_pkg::POOL_BYTES);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        fsa_pkg::CFG_FIT:  fit_r     <= cfg_wdata[1:0];
        fsa_pkg::CFG_POOL: cfgpool_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pool size applied at reinitialize, clamped to the legal range.
  always_comb begin
    if (cfgpool_r == '0) begin
      init_pool = SW'(1);
    end else if (cfgpool_r > SW'(fsa_pkg::POOL_BYTES)) begin
      init_pool = SW'(fsa_pkg::POOL_BYTES);
    end else begin
      init_pool = cfgpool_r;
    end
  end

  assign need        = {1'b0, inuse_r} + {1'b0, in_tdata[16:0]};
  assign scan_sum    = CW'(r0_r) + n_r;
  assign merge_idx   = left_r ? (bidx_r - IW'(1)) : bidx_r;
  assign merge_k     = {1'b0, left_r} + {1'b0, right_r};
  assign rov_ext     = CW'(rover_r);
  assign mk_end      = CW'(merge_idx) + CW'(merge_k);
  assign merged_size = (left_r ? lsize_r : SW'(0)) + bsize_r +
                       (right_r ? rsize_r : SW'(0));

  // Sequencer.
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    rover_nxt   = rover_r;
    inuse_nxt   = inuse_r;
    pool_nxt    = pool_r;
    op_nxt      = op_r;
    req_nxt     = req_r;
    addr_nxt    = addr_r;
    lim_nxt     = lim_r;
    n_nxt       = n_r;
    r0_nxt      = r0_r;
    qv_nxt      = 1'b0;
    qi_nxt      = qi_r;
    found_nxt   = found_r;
    bidx_nxt    = bidx_r;
    bstart_nxt  = bstart_r;
    bsize_nxt   = bsize_r;
    left_nxt    = left_r;
    right_nxt   = right_r;
    lstart_nxt  = lstart_r;
    lsize_nxt   = lsize_r;
    rsize_nxt   = rsize_r;
    pv_nxt      = pv_r;
    p_nxt       = p_r;
    pend_nxt    = 1'b0;
    pwa_nxt     = pwa_r;
    k_nxt       = k_r;
    status_nxt  = status_r;
    off_nxt     = off_r;
    holes_nxt   = holes_r;
    small_nxt   = small_r;
    largest_nxt = largest_r;
    probe_nxt   = probe_r;
    ovalid_nxt  = ovalid_r;
    odata_nxt   = odata_r;
    rd_addr     = '0;
    mem_we      = 1'b0;
    mem_wa      = '0;
    mem_wd      = '0;
    start_stat  = 1'b0;

    // The output register empties when the receiver takes it.
    if (ovalid_r && out_tready) begin
      ovalid_nxt = 1'b0;
    end

    unique case (state_r)
      // Write the reset segment after reset.
      S_INIT: begin
        mem_we       = 1'b1;
        mem_wa       = '0;
        mem_wd.start = '0;
        mem_wd.size  = SW'(fsa_pkg::POOL_BYTES);
        mem_wd.used  = 1'b0;
        state_nxt    = S_IDLE;
      end

      // Take a request and decide the first step.
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt     = fsa_pkg::op_t'(in_tuser);
          req_nxt    = in_tdata[16:0];
          addr_nxt   = in_tdata[32:17];
          lim_nxt    = in_tdata[49:33];
          status_nxt = fsa_pkg::ST_OK;
          off_nxt    = '0;
          found_nxt  = 1'b0;
          right_nxt  = 1'b0;
          left_nxt   = 1'b0;
          bsize_nxt  = '0;
          n_nxt      = '0;
          r0_nxt     = '0;
          unique case (fsa_pkg::op_t'(in_tuser))
            fsa_pkg::OP_ALLOC: begin
              if (in_tdata[16:0] == '0 || need > {1'b0, pool_r}) begin
                status_nxt = fsa_pkg::ST_NOFIT;
                start_stat = 1'b1;
              end else begin
                if (fit_r == fsa_pkg::FIT_NEXT && rov_ext < cnt_r) begin
                  r0_nxt = rover_r;
                end
                state_nxt = S_SRCH;
              end
            end
            fsa_pkg::OP_FREE: begin
              state_nxt = S_SRCH;
            end
            fsa_pkg::OP_QUERY: begin
              start_stat = 1'b1;
            end
            fsa_pkg::OP_REINIT: begin
              mem_we       = 1'b1;
              mem_wa       = '0;
              mem_wd.start = '0;
              mem_wd.size  = init_pool;
              mem_wd.used  = 1'b0;
              pool_nxt     = init_pool;
              cnt_nxt      = CW'(1);
              rover_nxt    = '0;
              inuse_nxt    = '0;
              start_stat   = 1'b1;
            end
            default: ;
          endcase
        end
      end

      // Walk the table for a fitting hole or the segment to free.
      S_SRCH: begin
        if (n_r < cnt_r) begin
          if (scan_sum >= cnt_r) begin
            rd_addr = IW'(scan_sum - cnt_r);
          end else begin
            rd_addr = IW'(scan_sum);
          end
          qv_nxt = 1'b1;
          qi_nxt = rd_addr;
          n_nxt  = n_r + CW'(1);
        end
        if (qv_r) begin
          if (op_r == fsa_pkg::OP_ALLOC) begin
            if (flags.fits && (!found_r ||
                (fit_r == fsa_pkg::FIT_BEST && flags.smaller) ||
                (fit_r == fsa_pkg::FIT_WORST && flags.larger))) begin
              found_nxt  = 1'b1;
              bidx_nxt   = qi_r;
              bstart_nxt = rd_q.start;
              bsize_nxt  = rd_q.size;
            end
          end else begin
            pv_nxt = rd_q;
            if (flags.free_match && !found_r) begin
              found_nxt  = 1'b1;
              bidx_nxt   = qi_r;
              bstart_nxt = rd_q.start;
              bsize_nxt  = rd_q.size;
              left_nxt   = (qi_r != '0) && !pv_r.used;
              lstart_nxt = pv_r.start;
              lsize_nxt  = pv_r.size;
            end else if (found_r && qi_r == bidx_r + IW'(1)) begin
              right_nxt = !rd_q.used;
              rsize_nxt = rd_q.size;
            end
          end
        end
        if (n_r == cnt_r && !qv_r) begin
          if (op_r == fsa_pkg::OP_ALLOC) begin
            if (!found_r) begin
              status_nxt = fsa_pkg::ST_NOFIT;
              start_stat = 1'b1;
            end else if (bsize_r > req_r) begin
              if (cnt_r == CW'(fsa_pkg::MAX_SEGMENTS)) begin
                status_nxt = fsa_pkg::ST_FULL;
                start_stat = 1'b1;
              end else begin
                p_nxt     = cnt_r - CW'(1);
                state_nxt = S_SHUP;
              end
            end else begin
              state_nxt = S_WIDX;
            end
          end else begin
            if (!found_r) begin
              status_nxt = fsa_pkg::ST_NOTFND;
              start_stat = 1'b1;
            end else begin
              state_nxt = S_FWR;
            end
          end
        end
      end

      // Move the entries above the split point up by one.
      S_SHUP: begin
        if (p_r > CW'(bidx_r)) begin
          rd_addr  = p_r[IW-1:0];
          pend_nxt = 1'b1;
          pwa_nxt  = p_r[IW-1:0] + IW'(1);
          p_nxt    = p_r - CW'(1);
        end
        if (pend_r) begin
          mem_we = 1'b1;
          mem_wa = pwa_r;
          mem_wd = rd_q;
        end
        if (!(p_r > CW'(bidx_r)) && !pend_r) begin
          state_nxt = S_WSPL;
        end
      end

      // Write the free remainder behind the new block.
      S_WSPL: begin
        mem_we       = 1'b1;
        mem_wa       = bidx_r + IW'(1);
        mem_wd.start = bstart_r + req_r[AW-1:0];
        mem_wd.size  = bsize_r - req_r;
        mem_wd.used  = 1'b0;
        cnt_nxt      = cnt_r + CW'(1);
        if (rover_r > bidx_r) begin
          rover_nxt = rover_r + IW'(1);
        end
        state_nxt = S_WIDX;
      end

      // Mark the chosen segment allocated.
      S_WIDX: begin
        mem_we       = 1'b1;
        mem_wa       = bidx_r;
        mem_wd.start = bstart_r;
        mem_wd.size  = req_r;
        mem_wd.used  = 1'b1;
        inuse_nxt    = inuse_r + req_r;
        off_nxt      = bstart_r;
        if (fit_r == fsa_pkg::FIT_NEXT) begin
          if (CW'(bidx_r) + CW'(1) < cnt_r) begin
            rover_nxt = bidx_r + IW'(1);
          end else begin
            rover_nxt = '0;
          end
        end
        start_stat = 1'b1;
      end

      // Write the merged hole and fix the rover.
      S_FWR: begin
        mem_we       = 1'b1;
        mem_wa       = merge_idx;
        mem_wd.start = left_r ? lstart_r : bstart_r;
        mem_wd.size  = merged_size;
        mem_wd.used  = 1'b0;
        inuse_nxt    = inuse_r - bsize_r;
        k_nxt        = merge_k;
        if (rov_ext > CW'(merge_idx) && rov_ext <= mk_end) begin
          rover_nxt = merge_idx;
        end else if (rov_ext > mk_end) begin
          rover_nxt = rover_r - IW'(merge_k);
        end
        if (merge_k != 2'd0) begin
          p_nxt     = mk_end + CW'(1);
          state_nxt = S_SHDN;
        end else begin
          start_stat = 1'b1;
        end
      end

      // Close the gap left by merged entries.
      S_SHDN: begin
        if (p_r < cnt_r) begin
          rd_addr  = p_r[IW-1:0];
          pend_nxt = 1'b1;
          pwa_nxt  = p_r[IW-1:0] - IW'(k_r);
          p_nxt    = p_r + CW'(1);
        end
        if (pend_r) begin
          mem_we = 1'b1;
          mem_wa = pwa_r;
          mem_wd = rd_q;
        end
        if (!(p_r < cnt_r) && !pend_r) begin
          cnt_nxt    = cnt_r - CW'(k_r);
          start_stat = 1'b1;
        end
      end

      // Gather the pool statistics over the table.
      S_STAT: begin
        if (n_r < cnt_r) begin
          rd_addr = n_r[IW-1:0];
          qv_nxt  = 1'b1;
          n_nxt   = n_r + CW'(1);
        end
        if (qv_r) begin
          if (!rd_q.used) begin
            holes_nxt = holes_r + CW'(1);
            if (rd_q.size > largest_r) begin
              largest_nxt = rd_q.size;
            end
            if (flags.small_hit) begin
              small_nxt = small_r + CW'(1);
            end
          end else if (flags.probe_hit) begin
            probe_nxt = 1'b1;
          end
        end
        if (n_r == cnt_r && !qv_r) begin
          state_nxt = S_DONE;
        end
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = {4'b0000, probe_r, small_r, largest_r, pool_r - inuse_r,
                        inuse_r, holes_r, off_r, status_r};
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Common entry into the statistics pass.
    if (start_stat) begin
      state_nxt   = S_STAT;
      n_nxt       = '0;
      holes_nxt   = '0;
      small_nxt   = '0;
      largest_nxt = '0;
      probe_nxt   = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT;
      cnt_r    <= CW'(1);
      rover_r  <= '0;
      inuse_r  <= '0;
      pool_r   <= SW'(fsa_pkg::POOL_BYTES);
      qv_r     <= 1'b0;
      pend_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      rover_r  <= rover_nxt;
      inuse_r  <= inuse_nxt;
      pool_r   <= pool_nxt;
      qv_r     <= qv_nxt;
      pend_r   <= pend_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    req_r     <= req_nxt;
    addr_r    <= addr_nxt;
    lim_r     <= lim_nxt;
    n_r       <= n_nxt;
    r0_r      <= r0_nxt;
    qi_r      <= qi_nxt;
    found_r   <= found_nxt;
    bidx_r    <= bidx_nxt;
    bstart_r  <= bstart_nxt;
    bsize_r   <= bsize_nxt;
    left_r    <= left_nxt;
    right_r   <= right_nxt;
    lstart_r  <= lstart_nxt;
    lsize_r   <= lsize_nxt;
    rsize_r   <= rsize_nxt;
    pv_r      <= pv_nxt;
    p_r       <= p_nxt;
    pwa_r     <= pwa_nxt;
    k_r       <= k_nxt;
    status_r  <= status_nxt;
    off_r     <= off_nxt;
    holes_r   <= holes_nxt;
    small_r   <= small_nxt;
    largest_r <= largest_nxt;
    probe_r   <= probe_nxt;
    odata_r   <= odata_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

`ifndef ASSERT_OFF
  // The table never becomes empty or overflows.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) && (cnt_r <= CW'(fsa_pkg::MAX_SEGMENTS)))
    else $error("segment count out of range");

  // Allocated bytes never exceed the active pool.
  a_inuse: assert property (@(posedge clk) disable iff (!rst_n)
    inuse_r <= pool_r)
    else $error("allocated bytes exceed pool");

  // An accepted item keeps the sequencer busy in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("sequencer ready right after accept");

  // A result is only loaded while the output register is free or taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && ovalid_r && !out_tready) |=> (state_r == S_DONE))
    else $error("result dropped while output stalled");
`endif

endmodule
`default_nettype wire

### tb/tb_top.sv
// Allocator testbench: directed table, table-full run, random requests, checked by a predictor.
`timescale 1ns / 1ps
module tb_top;

  // Clock, reset and ports.
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = '0;
  logic [55:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [16:0] cfg_wdata = '0;

  fit_strategy_segment_allocator_core dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // One request and one answer.
  typedef struct packed {
    fsa_pkg::op_t op;
    logic [16:0]  req_size;
    logic [15:0]  target_addr;
    logic [16:0]  small_limit;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] block_offset;
    logic [6:0]  hole_count;
    logic [16:0] allocated_bytes;
    logic [16:0] free_bytes;
    logic [16:0] largest_hole;
    logic [6:0]  small_hole_count;
    logic        probe_allocated;
  } answer_t;

  // Predictor copy of the pool state.
  logic [15:0] p_start [fsa_pkg::MAX_SEGMENTS+1];
  logic [16:0] p_size [fsa_pkg::MAX_SEGMENTS+1];
  logic        p_used [fsa_pkg::MAX_SEGMENTS+1];
  int          p_count, p_rover;
  int unsigned p_in_use, p_pool;
  logic [1:0]  p_fit;
  logic [16:0] p_pool_reg;

  answer_t     pending_answers[$];
  int          mismatches = 0;
  int          answers_seen = 0;
  int          accepted = 0;
  int          idle_cycles = 0;
  bit          hold_off = 1'b0;
  int          status_seen [4];

  function automatic void pool_reset();
    int unsigned p;
    p = p_pool_reg;
    if (p == 0) p = 1;
    if (p > fsa_pkg::POOL_BYTES) p = fsa_pkg::POOL_BYTES;
    p_pool = p;
    p_start[0] = '0;
    p_size[0] = 17'(p);
    p_used[0] = 1'b0;
    p_count = 1;
    p_rover = 0;
    p_in_use = 0;
  endfunction

  function automatic void drop_entry(int j);
    for (int k = j; k + 1 < p_count; k++) begin
      p_start[k] = p_start[k+1];
      p_size[k] = p_size[k+1];
      p_used[k] = p_used[k+1];
    end
    p_count--;
    if (p_rover == j) p_rover = j - 1;
    else if (p_rover > j) p_rover--;
  endfunction

  function automatic void merge_holes();
    int i;
    i = 0;
    while (i + 1 < p_count) begin
      if (!p_used[i] && !p_used[i+1]) begin
        p_size[i] = p_size[i] + p_size[i+1];
        drop_entry(i + 1);
      end else begin
        i++;
      end
    end
  endfunction

  function automatic void place_block(input int unsigned req, output logic [1:0] st,
                                      output logic [15:0] off);
    int idx, i, r;
    bit found;
    idx = 0;
    found = 0;
    off = '0;
    if (req == 0 || p_in_use + req > p_pool) begin
      st = fsa_pkg::ST_NOFIT;
      return;
    end
    if (p_fit == fsa_pkg::FIT_NEXT) begin
      r = (p_rover < p_count) ? p_rover : 0;
      for (int n = 0; n < p_count && !found; n++) begin
        i = (r + n) % p_count;
        if (!p_used[i] && p_size[i] >= req) begin
          idx = i;
          found = 1;
        end
      end
    end else begin
      for (i = 0; i < p_count; i++) begin
        if (p_used[i] || p_size[i] < req) continue;
        if (!found || (p_fit == fsa_pkg::FIT_BEST && p_size[i] < p_size[idx]) ||
            (p_fit == fsa_pkg::FIT_WORST && p_size[i] > p_size[idx])) begin
          idx = i;
          found = 1;
          if (p_fit == fsa_pkg::FIT_FIRST) break;
        end
      end
    end
    if (!found) begin
      st = fsa_pkg::ST_NOFIT;
      return;
    end
    if (p_size[idx] > req) begin
      if (p_count >= fsa_pkg::MAX_SEGMENTS) begin
        st = fsa_pkg::ST_FULL;
        return;
      end
      for (i = p_count; i > idx + 1; i--) begin
        p_start[i] = p_start[i-1];
        p_size[i] = p_size[i-1];
        p_used[i] = p_used[i-1];
      end
      p_start[idx+1] = 16'(p_start[idx] + req);
      p_size[idx+1] = 17'(p_size[idx] - req);
      p_used[idx+1] = 1'b0;
      p_count++;
      if (p_rover > idx) p_rover++;
      p_size[idx] = 17'(req);
    end
    p_used[idx] = 1'b1;
    p_in_use += req;
    off = p_start[idx];
    merge_holes();
    if (p_fit == fsa_pkg::FIT_NEXT) p_rover = (idx + 1 < p_count) ? idx + 1 : 0;
    st = fsa_pkg::ST_OK;
  endfunction

  function automatic answer_t predict_answer(request_t rq);
    answer_t a;
    int unsigned largest;
    a = '0;
    largest = 0;
    case (rq.op)
      fsa_pkg::OP_ALLOC: place_block(rq.req_size, a.status, a.block_offset);
      fsa_pkg::OP_FREE: begin
        a.status = fsa_pkg::ST_NOTFND;
        for (int i = 0; i < p_count; i++) begin
          if (p_start[i] == rq.target_addr && p_used[i]) begin
            p_used[i] = 1'b0;
            p_in_use -= p_size[i];
            merge_holes();
            a.status = fsa_pkg::ST_OK;
            break;
          end
        end
      end
      fsa_pkg::OP_REINIT: pool_reset();
      default: ;
    endcase
    for (int i = 0; i < p_count; i++) begin
      if (!p_used[i]) begin
        a.hole_count++;
        if (p_size[i] > largest) largest = p_size[i];
        if (p_size[i] <= rq.small_limit) a.small_hole_count++;
      end else if (rq.target_addr >= p_start[i] &&
                   rq.target_addr < p_start[i] + p_size[i]) begin
        a.probe_allocated = 1'b1;
      end
    end
    a.largest_hole = 17'(largest);
    a.allocated_bytes = 17'(p_in_use);
    a.free_bytes = 17'(p_pool - p_in_use);
    return a;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    mismatches++;
    $display("MISMATCH answer %0d %s: got %0d expected %0d", answers_seen, field, got,
             want);
  endtask

  // Check every answer taken from the block.
  always @(posedge clk) begin
    answer_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status           = out_tdata[1:0];
      got.block_offset     = out_tdata[17:2];
      got.hole_count       = out_tdata[24:18];
      got.allocated_bytes  = out_tdata[41:25];
      got.free_bytes       = out_tdata[58:42];
      got.largest_hole     = out_tdata[75:59];
      got.small_hole_count = out_tdata[82:76];
      got.probe_allocated  = out_tdata[83];
      if (pending_answers.size() == 0) begin
        mismatches++;
        $display("MISMATCH unexpected answer %0d", answers_seen);
      end else begin
        want = pending_answers.pop_front();
        status_seen[want.status]++;
        if (got.status != want.status) report_mismatch("status", got.status, want.status);
        if (got.block_offset != want.block_offset)
          report_mismatch("block_offset", got.block_offset, want.block_offset);
        if (got.hole_count != want.hole_count)
          report_mismatch("hole_count", got.hole_count, want.hole_count);
        if (got.allocated_bytes != want.allocated_bytes)
          report_mismatch("allocated_bytes", got.allocated_bytes, want.allocated_bytes);
        if (got.free_bytes != want.free_bytes)
          report_mismatch("free_bytes", got.free_bytes, want.free_bytes);
        if (got.largest_hole != want.largest_hole)
          report_mismatch("largest_hole", got.largest_hole, want.largest_hole);
        if (got.small_hole_count != want.small_hole_count)
          report_mismatch("small_hole_count", got.small_hole_count, want.small_hole_count);
        if (got.probe_allocated != want.probe_allocated)
          report_mismatch("probe_allocated", got.probe_allocated, want.probe_allocated);
      end
      answers_seen++;
    end
  end

  // Count accepted items on the input side.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) accepted++;
  end

  // Watchdog: cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("watchdog expired");
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    int g;
    if (hold_off) begin
      out_tready <= 1'b0;
    end else if (!out_tready) begin
      out_tready <= 1'b1;
    end else if (out_tvalid) begin
      g = gap_len();
      if (g > 0) begin
        out_tready <= 1'b0;
        repeat (g - 1) @(negedge clk);
      end
    end
  end

  // Offer one item from the next falling edge until it is accepted.
  task automatic send_request(request_t rq);
    answer_t a;
    @(negedge clk);
    in_tuser <= rq.op;
    in_tdata <= {6'd0, rq.small_limit, rq.target_addr, rq.req_size};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    a = predict_answer(rq);
    pending_answers.push_back(a);
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic send_with_gap(request_t rq);
    int g;
    g = gap_len();
    repeat (g) @(negedge clk);
    send_request(rq);
  endtask

  task automatic drain_answers();
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (3 * fsa_pkg::MAX_SEGMENTS + 20) @(negedge clk);
  endtask

  task automatic write_register(logic [0:0] idx, logic [16:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == fsa_pkg::CFG_FIT) p_fit = value[1:0];
    else p_pool_reg = value;
  endtask

  // Random request, mostly well-formed: frees hit live blocks.
  function automatic request_t random_request(int unsigned pool);
    request_t rq;
    int r;
    int live [$];
    r = $urandom_range(0, 99);
    rq.small_limit = ($urandom_range(0, 9) == 0) ? 17'($urandom_range(0, 131071))
                                                 : 17'($urandom_range(0, pool));
    rq.target_addr = 16'($urandom_range(0, 65535));
    rq.req_size = '0;
    for (int i = 0; i < p_count; i++) if (p_used[i]) live.push_back(p_start[i]);
    if (r < 50) begin
      rq.op = fsa_pkg::OP_ALLOC;
      case ($urandom_range(0, 9))
        0: rq.req_size = 17'($urandom_range(0, 131071));
        1: rq.req_size = 17'($urandom_range(pool / 2, pool));
        default: rq.req_size = 17'($urandom_range(1, (pool > 64) ? pool / 32 : pool));
      endcase
    end else if (r < 88) begin
      rq.op = fsa_pkg::OP_FREE;
      if (live.size() != 0 && $urandom_range(0, 9) != 0)
        rq.target_addr = 16'(live[$urandom_range(0, live.size() - 1)]);
    end else if (r < 98) begin
      rq.op = fsa_pkg::OP_QUERY;
      if (live.size() != 0 && r < 94)
        rq.target_addr = 16'(live[$urandom_range(0, live.size() - 1)] +
                             $urandom_range(0, 3));
    end else begin
      rq.op = fsa_pkg::OP_REINIT;
    end
    return rq;
  endfunction

  // Directed rows: request plus the answer when it is obvious.
  typedef struct {
    request_t rq;
    bit       typed;
    answer_t  want;
  } directed_row_t;

  directed_row_t rows [$];

  task automatic add_row(fsa_pkg::op_t op, int unsigned rs, int unsigned ta,
                         int unsigned sl, bit typed = 0, answer_t want = '0);
    directed_row_t d;
    d.rq = '{op, rs[16:0], ta[15:0], sl[16:0]};
    d.typed = typed;
    d.want = want;
    rows.push_back(d);
  endtask

  initial begin
    request_t rq;
    answer_t a;
    int fit_cycle;
    p_fit = fsa_pkg::FIT_FIRST;
    p_pool_reg = 17'd65536;
    pool_reset();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Empty pool after reset: one hole, nothing allocated.
    add_row(fsa_pkg::OP_QUERY, 0, 65535, 131071, 1,
            '{fsa_pkg::ST_OK, 0, 1, 0, 65536, 65536, 1, 0});
    add_row(fsa_pkg::OP_ALLOC, 0, 0, 0, 1,
            '{fsa_pkg::ST_NOFIT, 0, 1, 0, 65536, 65536, 0, 0});
    add_row(fsa_pkg::OP_ALLOC, 131071, 0, 0, 1,
            '{fsa_pkg::ST_NOFIT, 0, 1, 0, 65536, 65536, 0, 0});
    add_row(fsa_pkg::OP_ALLOC, 65537, 0, 65536, 1,
            '{fsa_pkg::ST_NOFIT, 0, 1, 0, 65536, 65536, 1, 0});
    add_row(fsa_pkg::OP_FREE, 0, 0, 0, 1,
            '{fsa_pkg::ST_NOTFND, 0, 1, 0, 65536, 65536, 0, 0});
    add_row(fsa_pkg::OP_ALLOC, 65536, 0, 0, 1,
            '{fsa_pkg::ST_OK, 0, 0, 65536, 0, 0, 0, 1});
    add_row(fsa_pkg::OP_QUERY, 0, 65535, 0, 1,
            '{fsa_pkg::ST_OK, 0, 0, 65536, 0, 0, 0, 1});
    add_row(fsa_pkg::OP_FREE, 0, 0, 0, 1,
            '{fsa_pkg::ST_OK, 0, 1, 0, 65536, 65536, 0, 0});
    add_row(fsa_pkg::OP_ALLOC, 1, 0, 1, 1,
            '{fsa_pkg::ST_OK, 0, 1, 1, 65535, 65535, 0, 1});
    add_row(fsa_pkg::OP_ALLOC, 100, 1, 100, 1,
            '{fsa_pkg::ST_OK, 1, 1, 101, 65435, 65435, 0, 1});
    add_row(fsa_pkg::OP_ALLOC, 50, 101, 65535);
    add_row(fsa_pkg::OP_FREE, 0, 1, 100);
    add_row(fsa_pkg::OP_FREE, 0, 1, 100);
    add_row(fsa_pkg::OP_FREE, 0, 5, 100);
    add_row(fsa_pkg::OP_ALLOC, 30, 0, 131071);
    add_row(fsa_pkg::OP_QUERY, 0, 151, 131071);
    add_row(fsa_pkg::OP_REINIT, 0, 0, 0, 1,
            '{fsa_pkg::ST_OK, 0, 1, 0, 65536, 65536, 0, 0});

    foreach (rows[i]) begin
      send_request(rows[i].rq);
      if (rows[i].typed && pending_answers[$] != rows[i].want) begin
        mismatches++;
        $display("MISMATCH directed row %0d predicted differently", i);
      end
    end
    drain_answers();

    // Fill the table to its limit and hit table full, then free blocks at every fourth byte address and allocate again.
    write_register(fsa_pkg::CFG_POOL, 17'd256);
    send_request('{fsa_pkg::OP_REINIT, 17'd0, 16'd0, 17'd0});
    for (int i = 0; i < fsa_pkg::MAX_SEGMENTS + 2; i++)
      send_request('{fsa_pkg::OP_ALLOC, 17'd2, 16'd0, 17'd3});
    send_request('{fsa_pkg::OP_ALLOC, 17'd1, 16'd0, 17'd3});
    for (int i = 0; i < 40; i++)
      send_request('{fsa_pkg::OP_FREE, 17'd0, 16'(i * 4), 17'd2});
    send_request('{fsa_pkg::OP_ALLOC, 17'd3, 16'd0, 17'd2});
    send_request('{fsa_pkg::OP_ALLOC, 17'd2, 16'd0, 17'd2});
    drain_answers();

    // Random phases: every strategy and a range of pool sizes.
    for (int ph = 0; ph < 16; ph++) begin
      int unsigned pool;
      case (ph % 4)
        0: pool = 65536;
        1: pool = $urandom_range(16, 2048);
        2: pool = (ph == 2) ? 0 : ((ph == 6) ? 131071 : $urandom_range(1, 65536));
        default: pool = $urandom_range(64, 512);
      endcase
      fit_cycle = ph % 4;
      write_register(fsa_pkg::CFG_FIT, 17'(fit_cycle));
      write_register(fsa_pkg::CFG_POOL, 17'(pool));
      send_request('{fsa_pkg::OP_REINIT, 17'd0, 16'd0, 17'd0});
      // Long receiver hold-off, timed on its own while items keep coming.
      if (ph == 5) begin
        hold_off = 1'b1;
        fork
          begin
            repeat (600) @(negedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < 65; n++) begin
        rq = random_request(p_pool);
        if (ph == 9 && n == 30) while (pending_answers.size() != 0) @(negedge clk);
        if (ph % 3 == 1) send_request(rq);
        else send_with_gap(rq);
      end
      drain_answers();
    end

    drain_answers();
    $display("covered %0d items over all four strategies and pool sizes 1 to 65536", accepted);
    $display("status counts ok %0d, no fit %0d, not found %0d, table full %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
